// ===== rtl/core/crbwl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crbwl_pkg
// shared widths and access codes for the byte/word/long word ram
// ---------------------------------------------------------------------------
package crbwl_pkg;

   localparam int WORD_W = 16;
   localparam int ADDR_W = 24;
   localparam int DATA_W = 32;

   typedef logic [1:0] size_type;

   localparam size_type SIZE_BYTE = 2'd0;
   localparam size_type SIZE_WORD = 2'd1;
   localparam size_type SIZE_LONG = 2'd2;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef struct packed {
      logic              we;
      logic [WORD_W-1:0] wdata;
   } mem_cmd_type;

endpackage

// ===== rtl/core/crbwl_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crbwl_ram
// single-port word memory with a registered read
// ---------------------------------------------------------------------------
module crbwl_ram #(
   parameter int RAM_WORDS = 262144
) (
   input  logic                             clock,
   input  logic [$clog2(RAM_WORDS)-1:0]     addr,
   input  crbwl_pkg::mem_cmd_type           cmd,
   output logic [crbwl_pkg::WORD_W-1:0]     rdata
);
   import crbwl_pkg::*;

   logic [WORD_W-1:0] word_mem [RAM_WORDS];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         word_mem[addr] <= cmd.wdata;
      end
      rdata_ff <= word_mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/chip_ram_byte_word_long_access.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chip_ram_byte_word_long_access
// big-endian word ram with byte, word and long access at a rebased address
// ---------------------------------------------------------------------------
// byte and word requests go from the request transfer to ST_FINISH; long
//   ones pass ST_SECOND for a second access on the single memory port;
//   the strobe is registered in ST_FINISH; a new request waits for idle
// reset: clears the ram one word a cycle, keeping busy high until it is done
// results are shown for one cycle; the receiver cannot stall
module chip_ram_byte_word_long_access #(
   parameter int RAM_WORDS = 262144
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_type,
   input  crbwl_pkg::size_type                 req_access_size,
   input  logic [crbwl_pkg::ADDR_W-1:0]        req_address,
   input  logic [crbwl_pkg::DATA_W-1:0]        req_write_data,
   output logic                                rsp_strobe,
   output logic [crbwl_pkg::DATA_W-1:0]        rsp_read_data,
   input  logic                                csr_we,
   input  logic [crbwl_pkg::ADDR_W-1:0]        csr_wdata
);
   import crbwl_pkg::*;

   localparam int AW = $clog2(RAM_WORDS);
   localparam logic [ADDR_W-1:0] BYTE_MASK = ADDR_W'(2 * RAM_WORDS - 1);
   localparam logic [AW-1:0] LAST_WORD = AW'(RAM_WORDS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SECOND,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [AW-1:0]       clr_ff;
   logic                type_ff;
   size_type            size_ff;
   logic                odd_ff;
   logic [DATA_W-1:0]   data_ff;
   logic [AW-1:0]       idx_ff;
   logic [WORD_W-1:0]   hi_ff;
   logic                rsp_strobe_ff;
   logic [DATA_W-1:0]   rsp_data_ff;

   logic                accept;
   logic [ADDR_W-1:0]   offset;
   logic [AW-1:0]       idx_in;
   logic [AW-1:0]       nxt_idx;
   logic [AW-1:0]       mem_addr;
   mem_cmd_type         mem_cmd;
   logic [WORD_W-1:0]   mem_rdata;
   logic [WORD_W-1:0]   merged;
   logic [DATA_W-1:0]   result;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign offset  = (req_address - base_ff) & BYTE_MASK;
   assign idx_in  = offset[AW:1];
   assign nxt_idx = (idx_ff == LAST_WORD) ? '0 : idx_ff + 1'b1;

   // byte lane merge
   always_comb begin
      if (odd_ff) begin
         merged = {mem_rdata[15:8], data_ff[7:0]};
      end else begin
         merged = {data_ff[7:0], mem_rdata[7:0]};
      end
   end

   always_comb begin
      result = '0;
      if (type_ff == REQ_READ) begin
         case (size_ff)
            SIZE_BYTE: result = {24'd0, odd_ff ? mem_rdata[7:0] : mem_rdata[15:8]};
            SIZE_WORD: result = {16'd0, mem_rdata};
            default:   result = {hi_ff, mem_rdata};
         endcase
      end
   end

   // memory port selection
   always_comb begin
      mem_addr      = idx_ff;
      mem_cmd.we    = 1'b0;
      mem_cmd.wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_addr   = clr_ff;
            mem_cmd.we = 1'b1;
         end
         ST_IDLE: begin
            mem_addr      = idx_in;
            mem_cmd.we    = accept && (req_type == REQ_WRITE)
                            && (req_access_size != SIZE_BYTE);
            mem_cmd.wdata = req_access_size[1] ? req_write_data[31:16]
                                               : req_write_data[15:0];
         end
         ST_SECOND: begin
            mem_addr      = nxt_idx;
            mem_cmd.we    = (type_ff == REQ_WRITE);
            mem_cmd.wdata = data_ff[15:0];
         end
         ST_FINISH: begin
            mem_addr      = idx_ff;
            mem_cmd.we    = (type_ff == REQ_WRITE) && (size_ff == SIZE_BYTE);
            mem_cmd.wdata = merged;
         end
         default: begin
            mem_addr = idx_ff;
         end
      endcase
   end

   crbwl_ram #(
      .RAM_WORDS (RAM_WORDS)
   ) u_ram (
      .clock (clock),
      .addr  (mem_addr),
      .cmd   (mem_cmd),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         base_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_WORD) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  type_ff  <= req_type;
                  size_ff  <= req_access_size;
                  odd_ff   <= req_address[0];
                  data_ff  <= req_write_data;
                  idx_ff   <= idx_in;
                  state_ff <= req_access_size[1] ? ST_SECOND : ST_FINISH;
               end
            end
            ST_SECOND: begin
               hi_ff    <= mem_rdata;
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               rsp_strobe_ff <= 1'b1;
               rsp_data_ff   <= result;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// ===== tb/tb_chip_ram_byte_word_long_access.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_chip_ram_byte_word_long_access
// checks the byte/word/long word ram against a mirror of its word store.
// a directed run covers lanes, odd addresses, the last-word wrap and the
// long alias of size code 3. Random phases follow, each under its own region
// base, mostly inside small hot windows so reads land on written words.
// every read_data strobe is compared with the oldest predicted value.
// ---------------------------------------------------------------------------
module tb_chip_ram_byte_word_long_access;
   import crbwl_pkg::*;

   localparam int RAM_WORDS = 262144;
   localparam int PHASE_ITEMS = 170;
   localparam int NUM_PHASES = 6;
   localparam longint LIMIT_CYCLES = 4 * (longint'(RAM_WORDS) + 1100 * 20);
   localparam size_type SIZE_LONG_ALIAS = 2'd3;
   localparam logic [23:0] LAST_WORD_WINDOW = 24'h07FFE0;

   class word_ram_mirror;
      bit [15:0] words [RAM_WORDS];
      logic [ADDR_W-1:0] region_base;
      logic [DATA_W-1:0] pending_read_data [$];
      int failures;

      function new();
         region_base = '0;
         failures = 0;
      endfunction

      function void set_region_base(logic [ADDR_W-1:0] value);
         region_base = value;
      endfunction

      function void note_transfer(logic is_write, size_type size,
                                  logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
         logic [ADDR_W-1:0] offset;
         int unsigned idx;
         int unsigned nxt;
         logic [15:0] w;
         logic [DATA_W-1:0] rd;
         offset = addr - region_base;
         idx = ((32'(offset) & (2 * RAM_WORDS - 1)) >> 1) % RAM_WORDS;
         nxt = (idx + 1) % RAM_WORDS;
         rd = '0;
         if ((size & SIZE_LONG) != '0) begin
            if (is_write == REQ_WRITE) begin
               words[idx] = data[31:16];
               words[nxt] = data[15:0];
            end else begin
               rd = {words[idx], words[nxt]};
            end
         end else if (size == SIZE_WORD) begin
            if (is_write == REQ_WRITE) words[idx] = data[15:0];
            else rd = {16'h0, words[idx]};
         end else begin
            w = words[idx];
            if (is_write == REQ_WRITE) begin
               if (addr[0]) w[7:0] = data[7:0];
               else w[15:8] = data[7:0];
               words[idx] = w;
            end else begin
               rd = {24'h0, (addr[0] ? w[7:0] : w[15:8])};
            end
         end
         pending_read_data.push_back(rd);
      endfunction

      function void check_read_data(logic [DATA_W-1:0] actual);
         logic [DATA_W-1:0] expected;
         if (pending_read_data.size() == 0) begin
            $error("read_data: unexpected transfer, actual %08h", actual);
            failures++;
         end else begin
            expected = pending_read_data.pop_front();
            if (actual !== expected) begin
               $error("read_data: expected %08h, actual %08h", expected, actual);
               failures++;
            end
         end
      endfunction

      function int outstanding();
         return pending_read_data.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   size_type            req_access_size;
   logic [ADDR_W-1:0]   req_address;
   logic [DATA_W-1:0]   req_write_data;
   logic                rsp_strobe;
   logic [DATA_W-1:0]   rsp_read_data;
   logic                csr_we;
   logic [ADDR_W-1:0]   csr_wdata;

   word_ram_mirror mirror = new();
   longint cycle_count = 0;
   int idle_pct = 0;

   chip_ram_byte_word_long_access #(
      .RAM_WORDS(RAM_WORDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_access_size(req_access_size),
      .req_address(req_address),
      .req_write_data(req_write_data),
      .rsp_strobe(rsp_strobe),
      .rsp_read_data(rsp_read_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1) mirror.check_read_data(rsp_read_data);
   end

   task automatic issue(input logic is_write, input size_type size,
                        input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= is_write;
      req_access_size <= size;
      req_address <= addr;
      req_write_data <= data;
      do @(posedge clock); while (busy !== 1'b0);
      mirror.note_transfer(is_write, size, addr, data);
   endtask

   // drain outstanding transfers, let the block settle, then write the base
   task automatic drain_and_set_base(input logic [ADDR_W-1:0] value);
      start <= 1'b0;
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror.set_region_base(value);
   endtask

   task automatic random_item(input logic [ADDR_W-1:0] base,
                              input logic [ADDR_W-1:0] mid_window);
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] window;
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         addr = ADDR_W'($urandom);
      end else begin
         case ($urandom_range(2))
            0: window = '0;
            1: window = LAST_WORD_WINDOW;
            default: window = mid_window;
         endcase
         addr = base + window + ADDR_W'($urandom_range(31))
                + (ADDR_W'($urandom_range(31)) << 19);
      end
      issue(1'($urandom_range(1)), size_type'($urandom_range(3)), addr, $urandom);
   endtask

   initial begin
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] mid_window;
      reset <= 1'b1;
      start <= 1'b0;
      req_type <= REQ_READ;
      req_access_size <= SIZE_BYTE;
      req_address <= '0;
      req_write_data <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);

      drain_and_set_base(24'h000000);
      idle_pct = 36;
      issue(REQ_WRITE, SIZE_LONG, 24'h000000, 32'hDEADBEEF);
      issue(REQ_READ,  SIZE_LONG, 24'h000000, 32'h0);
      issue(REQ_READ,  SIZE_WORD, 24'h000001, 32'h0);
      issue(REQ_READ,  SIZE_BYTE, 24'h000000, 32'h0);
      issue(REQ_READ,  SIZE_BYTE, 24'h000001, 32'h0);
      issue(REQ_WRITE, SIZE_BYTE, 24'h000001, 32'hFFFFFF5A);
      issue(REQ_READ,  SIZE_WORD, 24'h000000, 32'h0);
      issue(REQ_WRITE, SIZE_BYTE, 24'h000000, 32'h000000C3);
      issue(REQ_READ,  SIZE_LONG, 24'h000001, 32'h0);
      issue(REQ_WRITE, SIZE_LONG, 24'h07FFFE, 32'h12345678);
      issue(REQ_READ,  SIZE_WORD, 24'h000000, 32'h0);
      issue(REQ_READ,  SIZE_LONG, 24'h07FFFF, 32'h0);
      issue(REQ_WRITE, SIZE_LONG_ALIAS, 24'h000010, 32'hFFFFFFFF);
      issue(REQ_READ,  SIZE_LONG_ALIAS, 24'h000010, 32'h0);
      issue(REQ_READ,  SIZE_WORD, 24'h000012, 32'h0);
      issue(REQ_WRITE, SIZE_WORD, 24'hFFFFFE, 32'h0000FFFF);
      issue(REQ_READ,  SIZE_BYTE, 24'h07FFFF, 32'h0);
      issue(REQ_READ,  SIZE_LONG, 24'hF7FFFE, 32'h0);
      issue(REQ_WRITE, SIZE_WORD, 24'h000020, 32'h00000000);
      issue(REQ_READ,  SIZE_LONG, 24'h00001E, 32'h0);
      issue(REQ_READ,  SIZE_WORD, 24'h123456, 32'h0);
      issue(REQ_WRITE, SIZE_BYTE, 24'hFFFFFF, 32'hFFFFFFFF);
      issue(REQ_READ,  SIZE_WORD, 24'h7FFFFE, 32'h0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: base = 24'hFFFFFF;
            1: base = 24'h040000;
            2: base = 24'h000000;
            3: base = 24'h000001;
            default: base = ADDR_W'($urandom);
         endcase
         drain_and_set_base(base);
         idle_pct = (p < 2) ? 36 : ((p < 4) ? 71 : 0);
         mid_window = ADDR_W'($urandom_range(32'h7FFC0)) & ~ADDR_W'(1);
         for (int i = 0; i < PHASE_ITEMS; i++) random_item(base, mid_window);
      end

      start <= 1'b0;
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mirror.outstanding() != 0)
         $error("read_data: %0d transfers never arrived", mirror.outstanding());
      if (mirror.failures == 0 && mirror.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
